// File: sv/zlba_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the zoned log block allocator
// no dependencies; imported by every module of the block

package zlba_pkg;

  localparam int MAX_ZONES     = 1024;
  localparam int ZW            = $clog2(MAX_ZONES);   // zone index width
  localparam int ZCW           = ZW + 1;              // zone count width
  localparam int LBA_W         = 48;
  localparam int SEC_W         = 32;
  localparam int BS_W          = 9;
  localparam int SB_ZONE_COUNT = 2;

  // remainder unit: digits retired per cycle and digit steps per operation
  localparam int MOD_DIG   = 8;
  localparam int MOD_STEPS = LBA_W / MOD_DIG;
  localparam int MOD_CW    = $clog2(MOD_STEPS + 1);
  localparam int RW        = ZW;                      // remainder / divisor width

  localparam logic [3:0] COND_EMPTY         = 4'd1;
  localparam logic [3:0] COND_IMPLICIT_OPEN = 4'd2;

  localparam logic [2:0] ACT_LOAD    = 3'd0;
  localparam logic [2:0] ACT_INIT    = 3'd1;
  localparam logic [2:0] ACT_ALLOC   = 3'd2;
  localparam logic [2:0] ACT_RECLAIM = 3'd3;
  localparam logic [2:0] ACT_COUNT   = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_NOSPACE = 2'd2;
  localparam logic [1:0] STS_REFUSED = 2'd3;

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_BLOCK_SECTORS = 2'd0;
  localparam logic [1:0] REG_ZONE_SIZE     = 2'd1;
  localparam logic [1:0] REG_ZONE_CAPACITY = 2'd2;
  localparam logic [1:0] REG_TOTAL_ZONES   = 2'd3;

  typedef struct packed {
    logic [2:0]       action;
    logic [LBA_W-1:0] zone_start;
    logic [SEC_W-1:0] zone_length;
    logic [LBA_W-1:0] zone_write_pointer;
    logic [SEC_W-1:0] zone_cap;
    logic [3:0]       zone_condition;
    logic [1:0]       sb_zone_index;
    logic [9:0]       target_zone;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LBA_W-1:0] block_lba;
    logic [9:0]       head_zone;
    logic [10:0]      free_zones;
  } out_item_t;

  typedef struct packed {
    logic [BS_W-1:0]  block_sectors;
    logic [SEC_W-1:0] zone_size;
    logic [SEC_W-1:0] zone_capacity;
    logic [10:0]      total_zones;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SB_MODGO, S_SB_MOD, S_INIT_RD, S_INIT_MODGO, S_INIT_MOD,
    S_INIT_END, S_AL_MOD, S_AL_CRD, S_AL_CCHK, S_AL_COMMIT, S_RC_CHK, S_CNT_RD,
    S_CNT_CHK, S_DONE
  } fsm_state_t;

  typedef enum logic [1:0] {RD_SB, RD_IDX, RD_HEAD, RD_TARGET} rd_sel_t;

  typedef enum logic {MOD_WP, MOD_CAND} mod_sel_t;

  typedef enum logic [3:0] {
    UPD_NONE, UPD_LOAD, UPD_SB_LBA, UPD_SCAN_FIRST, UPD_INIT_CHK, UPD_INIT_END,
    UPD_CAND_FIRST, UPD_CAND_CHK, UPD_ALLOC_COMMIT, UPD_RECLAIM, UPD_CNT_CHK
  } upd_t;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       mod_start;
    mod_sel_t   mod_sel;
    upd_t       upd;
    logic       set_status;
    logic [1:0] status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       init_refuse;
    logic       sb_bad;
    logic       exhausted;
    logic       ndata_zero;
    logic       count_none;
    logic       recl_bad;
    logic       recl_busy;
    logic       mod_busy;
    logic       rd_empty;
    logic       init_partial;
    logic       idx_last;
    logic       step_last;
  } sts_t;

endpackage

// File: sv/zlba_mod.sv
`timescale 1ns / 1ps
// multi-cycle remainder unit, eight dividend bits per cycle
// depends on zlba_pkg

module zlba_mod
  import zlba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [LBA_W-1:0] dividend,
  input  logic [RW-1:0]    divisor,
  output logic             busy,
  output logic [RW-1:0]    rem
);

  logic              busy_r;
  logic [MOD_CW-1:0] cnt_r;
  logic [LBA_W-1:0]  dvd_r;
  logic [RW-1:0]     dvs_r;
  logic [RW-1:0]     rem_r;
  logic [RW-1:0]     rem_nxt;

  // restoring remainder over one digit group
  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = rem_r;
    for (int k = 0; k < MOD_DIG; k++) begin
      t = {r, dvd_r[LBA_W-1-k]};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
      end
      r = t[RW-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= MOD_CW'(MOD_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - MOD_CW'(1);
      if (cnt_r == MOD_CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << MOD_DIG;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// File: sv/zlba_dp.sv
`timescale 1ns / 1ps
// datapath: zone table memories, log head registers, result register
// depends on zlba_pkg and zlba_mod

module zlba_dp
  import zlba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  // zone table
  logic [LBA_W-1:0] start_mem [MAX_ZONES];
  logic [LBA_W-1:0] wp_mem    [MAX_ZONES];
  logic [SEC_W-1:0] cap_mem   [MAX_ZONES];
  logic [3:0]       cond_mem  [MAX_ZONES];

  logic [LBA_W-1:0] rd_start_r, rd_wp_r;
  logic [SEC_W-1:0] rd_cap_r;
  logic [3:0]       rd_cond_r;

  // architectural state
  logic [ZCW-1:0]   zl_r;
  logic [ZW-1:0]    head_r;
  logic [LBA_W-1:0] next_r, end_r;

  // working registers
  in_item_t         in_r;
  logic [ZW-1:0]    idx_r;
  logic [ZCW-1:0]   step_r;
  logic             emp_found_r;
  logic [ZW-1:0]    emp_idx_r;
  logic [LBA_W-1:0] emp_start_r, emp_end_r, z2_start_r;
  logic [1:0]       res_status_r;
  logic [LBA_W-1:0] res_lba_r;
  logic [10:0]      res_free_r;
  out_item_t        out_r;

  logic [BS_W-1:0]  bpb;
  logic [ZCW-1:0]   ndata;
  logic [ZW-1:0]    rd_addr;
  logic [LBA_W-1:0] rd_end;
  logic [LBA_W-1:0] mod_dvd;
  logic [RW-1:0]    mod_dvs;
  logic             mod_busy;
  logic [RW-1:0]    mod_rem;
  logic             load_ok, load_bad, load_refuse;
  logic             wp_we, cond_we;
  logic [ZW-1:0]    wp_wa, cond_wa;
  logic [LBA_W-1:0] wp_wd;
  logic [3:0]       cond_wd;
  logic [LBA_W-1:0] next_step;

  assign bpb       = (cfg.block_sectors == '0) ? BS_W'(1) : cfg.block_sectors;
  assign ndata     = (zl_r > ZCW'(SB_ZONE_COUNT)) ? zl_r - ZCW'(SB_ZONE_COUNT) : '0;
  assign rd_end    = rd_start_r + LBA_W'(rd_cap_r);
  assign next_step = next_r + LBA_W'(bpb);

  always_comb begin
    case (cmd.rd_sel)
      RD_SB:     rd_addr = ZW'(in_r.sb_zone_index);
      RD_IDX:    rd_addr = idx_r;
      RD_HEAD:   rd_addr = head_r;
      RD_TARGET: rd_addr = in_r.target_zone;
      default:   rd_addr = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.mod_sel)
      MOD_CAND: begin
        mod_dvd = LBA_W'(head_r - ZW'(1));
        mod_dvs = ndata[RW-1:0];
      end
      default: begin
        mod_dvd = rd_wp_r - rd_start_r;
        mod_dvs = RW'(bpb);
      end
    endcase
  end

  zlba_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_dvs),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  assign load_refuse = (zl_r >= ZCW'(cfg.total_zones)) || (zl_r >= ZCW'(MAX_ZONES));
  assign load_bad    = (in_r.zone_length != cfg.zone_size) ||
                       (in_r.zone_cap < cfg.zone_capacity);
  assign load_ok     = (cmd.upd == UPD_LOAD) && !load_refuse && !load_bad;

  // write ports of the wp and condition stores
  always_comb begin
    wp_we   = 1'b0;
    wp_wa   = head_r;
    wp_wd   = next_step;
    cond_we = 1'b0;
    cond_wa = head_r;
    cond_wd = COND_IMPLICIT_OPEN;
    case (cmd.upd)
      UPD_LOAD: begin
        wp_we   = load_ok;
        wp_wa   = zl_r[ZW-1:0];
        wp_wd   = in_r.zone_write_pointer;
        cond_we = load_ok;
        cond_wa = zl_r[ZW-1:0];
        cond_wd = in_r.zone_condition;
      end
      UPD_ALLOC_COMMIT: begin
        wp_we   = 1'b1;
        cond_we = (rd_cond_r == COND_EMPTY);
      end
      UPD_RECLAIM: begin
        wp_we   = 1'b1;
        wp_wa   = in_r.target_zone;
        wp_wd   = rd_start_r;
        cond_we = 1'b1;
        cond_wa = in_r.target_zone;
        cond_wd = COND_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      start_mem[zl_r[ZW-1:0]] <= in_r.zone_start;
    end
    if (cmd.rd_en) begin
      rd_start_r <= start_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      cap_mem[zl_r[ZW-1:0]] <= in_r.zone_cap;
    end
    if (cmd.rd_en) begin
      rd_cap_r <= cap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wp_we) begin
      wp_mem[wp_wa] <= wp_wd;
    end
    if (cmd.rd_en) begin
      rd_wp_r <= wp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cond_we) begin
      cond_mem[cond_wa] <= cond_wd;
    end
    if (cmd.rd_en) begin
      rd_cond_r <= cond_mem[rd_addr];
    end
  end

  // status toward the controller
  always_comb begin
    sts.action       = in_r.action;
    sts.init_refuse  = (zl_r < cfg.total_zones) || (zl_r < ZCW'(SB_ZONE_COUNT + 1));
    sts.sb_bad       = (in_r.sb_zone_index >= 2'(SB_ZONE_COUNT));
    sts.exhausted    = ({1'b0, head_r} >= zl_r) ||
                       ({1'b0, next_r} + (LBA_W+1)'(bpb) > {1'b0, end_r});
    sts.ndata_zero   = (ndata == '0);
    sts.count_none   = (zl_r <= ZCW'(SB_ZONE_COUNT));
    sts.recl_bad     = (in_r.target_zone < ZW'(SB_ZONE_COUNT)) ||
                       ({1'b0, in_r.target_zone} >= zl_r);
    sts.recl_busy    = (in_r.target_zone == head_r) && (next_r < end_r);
    sts.mod_busy     = mod_busy;
    sts.rd_empty     = (rd_wp_r == rd_start_r);
    sts.init_partial = (rd_wp_r > rd_start_r) && (rd_wp_r < rd_end) &&
                       (mod_rem == '0) && ((rd_end - rd_wp_r) >= LBA_W'(bpb));
    sts.idx_last     = ({1'b0, idx_r} + ZCW'(1) == zl_r);
    sts.step_last    = (step_r == ndata);
  end

  // log head and table count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zl_r        <= '0;
      head_r      <= ZW'(SB_ZONE_COUNT);
      next_r      <= '0;
      end_r       <= '0;
      emp_found_r <= 1'b0;
    end else begin
      case (cmd.upd)
        UPD_LOAD: begin
          if (!load_refuse) begin
            zl_r <= load_bad ? '0 : zl_r + ZCW'(1);
          end
        end
        UPD_SCAN_FIRST: begin
          emp_found_r <= 1'b0;
        end
        UPD_INIT_CHK: begin
          if (sts.init_partial) begin
            head_r <= idx_r;
            next_r <= rd_wp_r;
            end_r  <= rd_end;
          end else if (sts.rd_empty && !emp_found_r) begin
            emp_found_r <= 1'b1;
          end
        end
        UPD_INIT_END: begin
          if (emp_found_r) begin
            head_r <= emp_idx_r;
            next_r <= emp_start_r;
            end_r  <= emp_end_r;
          end else begin
            head_r <= ZW'(SB_ZONE_COUNT);
            next_r <= z2_start_r;
            end_r  <= z2_start_r;
          end
        end
        UPD_CAND_CHK: begin
          if (sts.rd_empty) begin
            head_r <= idx_r;
            next_r <= rd_start_r;
            end_r  <= rd_end;
          end
        end
        UPD_ALLOC_COMMIT: begin
          next_r <= next_step;
        end
        default: begin
        end
      endcase
    end
  end

  // scan pointers, result hold and output register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r         <= in_data;
      res_status_r <= STS_OK;
      res_lba_r    <= '0;
      res_free_r   <= '0;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    case (cmd.upd)
      UPD_LOAD: begin
        if (load_refuse) begin
          res_status_r <= STS_REFUSED;
        end else if (load_bad) begin
          res_status_r <= STS_INVALID;
        end
      end
      UPD_SB_LBA: begin
        res_lba_r <= (mod_rem != '0) ? rd_start_r + LBA_W'(cfg.zone_capacity) : rd_wp_r;
      end
      UPD_SCAN_FIRST: begin
        idx_r <= ZW'(SB_ZONE_COUNT);
      end
      UPD_INIT_CHK: begin
        if (idx_r == ZW'(SB_ZONE_COUNT)) begin
          z2_start_r <= rd_start_r;
        end
        if (!sts.init_partial && sts.rd_empty && !emp_found_r) begin
          emp_idx_r   <= idx_r;
          emp_start_r <= rd_start_r;
          emp_end_r   <= rd_end;
        end
        idx_r <= idx_r + ZW'(1);
      end
      UPD_CAND_FIRST: begin
        idx_r  <= ZW'(SB_ZONE_COUNT) + mod_rem;
        step_r <= ZCW'(1);
      end
      UPD_CAND_CHK: begin
        if (!sts.rd_empty) begin
          step_r <= step_r + ZCW'(1);
          idx_r  <= ({1'b0, idx_r} + ZCW'(1) == zl_r) ? ZW'(SB_ZONE_COUNT) : idx_r + ZW'(1);
        end
      end
      UPD_ALLOC_COMMIT: begin
        res_lba_r <= next_r;
      end
      UPD_CNT_CHK: begin
        if (idx_r != head_r && sts.rd_empty) begin
          res_free_r <= res_free_r + 11'd1;
        end
        idx_r <= idx_r + ZW'(1);
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_r.status     <= res_status_r;
      out_r.block_lba  <= res_lba_r;
      out_r.head_zone  <= head_r;
      out_r.free_zones <= res_free_r;
    end
  end

  assign out_data = out_r;

  a_zl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    zl_r <= ZCW'(MAX_ZONES))
    else $error("zone count beyond table depth");

  a_head_data: assert property (@(posedge clk) disable iff (!rst_n)
    head_r >= ZW'(SB_ZONE_COUNT))
    else $error("log head on a superblock zone");

  a_stride_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bpb != '0)
    else $error("allocation stride is zero");

endmodule

// File: sv/zlba_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences each action over the datapath, owns the handshakes
// depends on zlba_pkg

module zlba_ctrl
  import zlba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.action)
          ACT_INIT: begin
            if (sts.init_refuse || sts.sb_bad) state_nxt = S_DONE;
            else state_nxt = S_SB_MODGO;
          end
          ACT_ALLOC: begin
            if (!sts.exhausted) state_nxt = S_AL_COMMIT;
            else if (sts.ndata_zero) state_nxt = S_DONE;
            else state_nxt = S_AL_MOD;
          end
          ACT_RECLAIM: begin
            if (sts.recl_bad || sts.recl_busy) state_nxt = S_DONE;
            else state_nxt = S_RC_CHK;
          end
          ACT_COUNT: begin
            if (sts.count_none) state_nxt = S_DONE;
            else state_nxt = S_CNT_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SB_MODGO: state_nxt = S_SB_MOD;
      S_SB_MOD: begin
        if (!sts.mod_busy) state_nxt = S_INIT_RD;
      end
      S_INIT_RD:    state_nxt = S_INIT_MODGO;
      S_INIT_MODGO: state_nxt = S_INIT_MOD;
      S_INIT_MOD: begin
        if (!sts.mod_busy) begin
          if (sts.init_partial) state_nxt = S_DONE;
          else if (sts.idx_last) state_nxt = S_INIT_END;
          else state_nxt = S_INIT_RD;
        end
      end
      S_INIT_END: state_nxt = S_DONE;
      S_AL_MOD: begin
        if (!sts.mod_busy) state_nxt = S_AL_CRD;
      end
      S_AL_CRD: state_nxt = S_AL_CCHK;
      S_AL_CCHK: begin
        if (sts.rd_empty) state_nxt = S_AL_COMMIT;
        else if (sts.step_last) state_nxt = S_DONE;
        else state_nxt = S_AL_CRD;
      end
      S_AL_COMMIT: state_nxt = S_DONE;
      S_RC_CHK:    state_nxt = S_DONE;
      S_CNT_RD:    state_nxt = S_CNT_CHK;
      S_CNT_CHK: begin
        if (sts.idx_last) state_nxt = S_DONE;
        else state_nxt = S_CNT_RD;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel  = RD_IDX;
    cmd.mod_sel = MOD_WP;
    cmd.upd     = UPD_NONE;
    cmd.status  = STS_OK;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
      end
      S_DISPATCH: begin
        case (sts.action)
          ACT_LOAD: cmd.upd = UPD_LOAD;
          ACT_INIT: begin
            if (sts.init_refuse) begin
              cmd.set_status = 1'b1;
              cmd.status     = STS_REFUSED;
            end else if (sts.sb_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = STS_INVALID;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_SB;
            end
          end
          ACT_ALLOC: begin
            if (!sts.exhausted) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
            end else if (sts.ndata_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = STS_NOSPACE;
            end else begin
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = MOD_CAND;
            end
          end
          ACT_RECLAIM: begin
            if (sts.recl_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = STS_INVALID;
            end else if (sts.recl_busy) begin
              cmd.set_status = 1'b1;
              cmd.status     = STS_REFUSED;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TARGET;
            end
          end
          ACT_COUNT: begin
            if (!sts.count_none) cmd.upd = UPD_SCAN_FIRST;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = STS_INVALID;
          end
        endcase
      end
      S_SB_MODGO: begin
        cmd.mod_start = 1'b1;
        cmd.upd       = UPD_SCAN_FIRST;
      end
      S_SB_MOD: begin
        if (!sts.mod_busy) cmd.upd = UPD_SB_LBA;
      end
      S_INIT_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_INIT_MODGO: begin
        cmd.mod_start = 1'b1;
      end
      S_INIT_MOD: begin
        if (!sts.mod_busy) cmd.upd = UPD_INIT_CHK;
      end
      S_INIT_END: cmd.upd = UPD_INIT_END;
      S_AL_MOD: begin
        cmd.mod_sel = MOD_CAND;
        if (!sts.mod_busy) cmd.upd = UPD_CAND_FIRST;
      end
      S_AL_CRD: begin
        cmd.rd_en = 1'b1;
      end
      S_AL_CCHK: begin
        cmd.upd = UPD_CAND_CHK;
        if (!sts.rd_empty && sts.step_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = STS_NOSPACE;
        end
      end
      S_AL_COMMIT: cmd.upd = UPD_ALLOC_COMMIT;
      S_RC_CHK: begin
        if (sts.rd_empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = STS_REFUSED;
        end else begin
          cmd.upd = UPD_RECLAIM;
        end
      end
      S_CNT_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_CNT_CHK: cmd.upd = UPD_CNT_CHK;
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISPATCH)
    else $error("accepted transfer not dispatched");

  a_mod_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_start |-> !sts.mod_busy)
    else $error("remainder unit restarted while busy");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not posted");

endmodule

// File: sv/zoned_log_block_allocator.sv
`timescale 1ns / 1ps
// top level: configuration registers, controller and datapath
// depends on zlba_pkg, zlba_ctrl, zlba_dp

// Zone table plus circular data-log allocator. One item is worked at a
// time; a result waits in the output register while the next item is taken.
// Each item is accepted, dispatched and its result posted; load and
// refusals add nothing, reclaim and an allocation in the head zone add a
// table read, count reads each data zone, init runs the remainder unit on
// the superblock zone, then per data zone scanned a table read and the
// remainder unit checking block alignment, and a wrapping allocation runs
// the remainder unit for the first candidate, then a read per zone tried.
// Pace is set by the table's single read port and the remainder unit, which
// retires 8 of the 48 bits per cycle. The table comes up undefined and
// needs no clearing: entries beyond the loaded count are never consulted.

module zoned_log_block_allocator
  import zlba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  // apb access: write lands in the access phase, never stalls
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_sectors <= BS_W'(8);
      cfg_r.zone_size     <= SEC_W'(524288);
      cfg_r.zone_capacity <= SEC_W'(524288);
      cfg_r.total_zones   <= 11'd1024;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BLOCK_SECTORS: cfg_r.block_sectors <= pwdata[BS_W-1:0];
        REG_ZONE_SIZE:     cfg_r.zone_size     <= pwdata;
        REG_ZONE_CAPACITY: cfg_r.zone_capacity <= pwdata;
        REG_TOTAL_ZONES:   cfg_r.total_zones   <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  // read-back of the register file
  always_comb begin
    case (paddr[3:2])
      REG_BLOCK_SECTORS: prdata = 32'(cfg_r.block_sectors);
      REG_ZONE_SIZE:     prdata = cfg_r.zone_size;
      REG_ZONE_CAPACITY: prdata = cfg_r.zone_capacity;
      REG_TOTAL_ZONES:   prdata = 32'(cfg_r.total_zones);
      default:           prdata = '0;
    endcase
  end

  // sequencer: one state per table access or remainder wait
  zlba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // zone table, log head and result transfer register
  zlba_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for zoned_log_block_allocator
// depends on zlba_pkg and the block's rtl; drives items and config, checks every result

module tb
  import zlba_pkg::*;
;

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  // action codes the block does not implement
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  zoned_log_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block: zone table, log head and registers
  logic [47:0] tab_start [MAX_ZONES];
  logic [47:0] tab_wp    [MAX_ZONES];
  logic [31:0] tab_cap   [MAX_ZONES];
  logic [3:0]  tab_cond  [MAX_ZONES];
  int          n_loaded = 0;
  int          head_idx = SB_ZONE_COUNT;
  logic [63:0] head_next = '0;
  logic [63:0] head_end = '0;
  logic [8:0]  cfg_bs = 9'd8;
  logic [31:0] cfg_zsize = 32'd524288;
  logic [31:0] cfg_zcap = 32'd524288;
  logic [10:0] cfg_total = 11'd1024;

  in_item_t  zone_cmds[$];       // items waiting to be offered
  out_item_t pending_results[$]; // results owed by the block
  int        n_queued = 0;
  int        n_errors = 0;
  bit        tx_idle = 1'b0;     // sender inserts gaps
  bit        rx_idle = 1'b0;     // receiver stalls
  bit        hold_arm = 1'b0;    // ask receiver for one long hold-off
  int        tx_gap = 0;
  int        rx_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  out_item_t want;

  initial forever #6 clk = ~clk;

  initial begin
    #15ms;
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] blk_stride();
    return (cfg_bs == 0) ? 64'd1 : 64'(cfg_bs);
  endfunction

  function automatic bit zone_is_empty(int i);
    return tab_wp[i] == tab_start[i];
  endfunction

  // apply one action to the shadow state and return the result it owes
  function automatic out_item_t zone_action(in_item_t it);
    out_item_t   r;
    logic [63:0] bpb, s, w, e, lba;
    int          i, nd, cand, stp, nfree, t;
    bit          found;
    r = '0;
    bpb = blk_stride();
    lba = '0;
    nfree = 0;
    found = 1'b0;
    cand = 0;
    r.status = STS_OK;
    case (it.action)
      ACT_LOAD: begin
        if (n_loaded >= int'(cfg_total) || n_loaded >= MAX_ZONES) begin
          r.status = STS_REFUSED;
        end else if (it.zone_length != cfg_zsize || it.zone_cap < cfg_zcap) begin
          n_loaded = 0;    // bad geometry drops the whole table
          r.status = STS_INVALID;
        end else begin
          tab_start[n_loaded] = it.zone_start;
          tab_wp[n_loaded] = it.zone_write_pointer;
          tab_cap[n_loaded] = it.zone_cap;
          tab_cond[n_loaded] = it.zone_condition;
          n_loaded++;
        end
      end
      ACT_INIT: begin
        if (n_loaded < int'(cfg_total) || n_loaded < SB_ZONE_COUNT + 1) begin
          r.status = STS_REFUSED;
        end else if (it.sb_zone_index >= SB_ZONE_COUNT) begin
          r.status = STS_INVALID;
        end else begin
          s = 64'(tab_start[it.sb_zone_index]);
          w = 64'(tab_wp[it.sb_zone_index]);
          // a torn superblock zone counts as full
          if ((((w - s) & MASK48) % bpb) != 0) lba = (s + 64'(cfg_zcap)) & MASK48;
          else lba = w;
          // first choice: a partly written, block aligned data zone with room
          for (i = SB_ZONE_COUNT; i < n_loaded && !found; i++) begin
            s = 64'(tab_start[i]);
            w = 64'(tab_wp[i]);
            e = (s + 64'(tab_cap[i])) & MASK48;
            if (w > s && w < e && ((w - s) % bpb) == 0 && e - w >= bpb) begin
              head_idx = i;
              head_next = w;
              found = 1'b1;
            end
          end
          for (i = SB_ZONE_COUNT; i < n_loaded && !found; i++) begin
            if (zone_is_empty(i)) begin
              head_idx = i;
              head_next = 64'(tab_start[i]);
              found = 1'b1;
            end
          end
          if (found) begin
            head_end = (64'(tab_start[head_idx]) + 64'(tab_cap[head_idx])) & MASK48;
          end else begin
            head_idx = SB_ZONE_COUNT;
            head_next = 64'(tab_start[SB_ZONE_COUNT]);
            head_end = head_next;
          end
        end
      end
      ACT_ALLOC: begin
        if (head_idx >= n_loaded || head_next + bpb > head_end) begin
          nd = (n_loaded > SB_ZONE_COUNT) ? n_loaded - SB_ZONE_COUNT : 0;
          for (stp = 1; stp <= nd && !found; stp++) begin
            cand = SB_ZONE_COUNT + ((head_idx - SB_ZONE_COUNT + stp) % nd);
            found = zone_is_empty(cand);
          end
          if (!found) begin
            r.status = STS_NOSPACE;
          end else begin
            head_idx = cand;
            head_next = 64'(tab_start[cand]);
            head_end = (64'(tab_start[cand]) + 64'(tab_cap[cand])) & MASK48;
          end
        end
        if (r.status == STS_OK) begin
          lba = head_next;
          head_next = (head_next + bpb) & MASK48;
          tab_wp[head_idx] = head_next[47:0];
          if (tab_cond[head_idx] == COND_EMPTY) tab_cond[head_idx] = COND_IMPLICIT_OPEN;
        end
      end
      ACT_RECLAIM: begin
        t = int'(it.target_zone);
        if (t < SB_ZONE_COUNT || t >= n_loaded) r.status = STS_INVALID;
        else if (t == head_idx && head_next < head_end) r.status = STS_REFUSED;
        else if (zone_is_empty(t)) r.status = STS_REFUSED;
        else begin
          tab_wp[t] = tab_start[t];
          tab_cond[t] = COND_EMPTY;
        end
      end
      ACT_COUNT: begin
        for (i = SB_ZONE_COUNT; i < n_loaded; i++)
          if (i != head_idx && zone_is_empty(i)) nfree++;
      end
      default: r.status = STS_INVALID;
    endcase
    r.block_lba = lba[47:0];
    r.head_zone = head_idx[9:0];
    r.free_zones = nfree[10:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
    n_errors++;
  endtask

  // sender: offers queued items, predicts each one at its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) pending_results.push_back(zone_action(in_data));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (zone_cmds.size() > 0) begin
          in_data <= zone_cmds.pop_front();
          in_valid <= 1'b1;
          tx_gap <= tx_idle ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle && $urandom_range(0, 3) == 0) rx_gap <= idle_len();
    end
  end

  // result check against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, status", 64'(out_data.status), 64'(STS_OK));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status)
          report("status", 64'(out_data.status), 64'(want.status));
        if (out_data.block_lba != want.block_lba)
          report("block_lba", 64'(out_data.block_lba), 64'(want.block_lba));
        if (out_data.head_zone != want.head_zone)
          report("head_zone", 64'(out_data.head_zone), 64'(want.head_zone));
        if (out_data.free_zones != want.free_zones)
          report("free_zones", 64'(out_data.free_zones), 64'(want.free_zones));
      end
    end
  end

  // setup and access cycle; the register takes the value at the access edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BLOCK_SECTORS: cfg_bs = val[8:0];
      REG_ZONE_SIZE:     cfg_zsize = val;
      REG_ZONE_CAPACITY: cfg_zcap = val;
      default:           cfg_total = val[10:0];
    endcase
  endtask

  task automatic set_geometry(logic [31:0] bs, logic [31:0] zs, logic [31:0] zc,
                              logic [31:0] tot);
    write_reg(REG_BLOCK_SECTORS, bs);
    write_reg(REG_ZONE_SIZE, zs);
    write_reg(REG_ZONE_CAPACITY, zc);
    write_reg(REG_TOTAL_ZONES, tot);
  endtask

  // every transfer done and every result back, then a short settle
  task automatic wait_idle(int settle);
    do @(negedge clk);
    while (zone_cmds.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // item with random filler in every field the action does not use
  function automatic in_item_t any_item(logic [2:0] act);
    logic [191:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.action = act;
    return it;
  endfunction

  task automatic push(in_item_t it);
    zone_cmds.push_back(it);
    n_queued++;
  endtask

  task automatic push_op(logic [2:0] act, logic [1:0] sbi, logic [9:0] tz);
    in_item_t it;
    it = any_item(act);
    it.sb_zone_index = sbi;
    it.target_zone = tz;
    push(it);
  endtask

  task automatic push_load(logic [47:0] st, logic [31:0] len, logic [47:0] wp,
                           logic [31:0] cap, logic [3:0] cond);
    in_item_t it;
    it = any_item(ACT_LOAD);
    it.zone_start = st;
    it.zone_length = len;
    it.zone_write_pointer = wp;
    it.zone_cap = cap;
    it.zone_condition = cond;
    push(it);
  endtask

  // a zone report that passes the geometry check, in a random fill state
  task automatic push_good_zone(bit sb);
    logic [63:0] bpb, st, cap, wp, m, nblk;
    logic [3:0]  cond;
    int          kind;
    bpb = blk_stride();
    st = {$urandom, $urandom} & MASK48;
    if ($urandom_range(0, 2) == 0) st = 64'($urandom_range(0, 4096));
    cap = 64'(cfg_zcap);
    if ($urandom_range(0, 3) == 0 && cap + 3 * bpb <= 64'hFFFF_FFFF)
      cap = cap + 64'($urandom_range(0, 3)) * bpb;
    nblk = cap / bpb;
    cond = 4'($urandom_range(0, 15));
    kind = $urandom_range(0, 99);
    if (sb) kind = (kind < 60) ? 50 : 95;
    if (kind < 40) begin
      wp = st;
      if ($urandom_range(0, 3) != 0) cond = COND_EMPTY;
    end else if (kind < 65) begin
      m = (nblk > 1) ? 64'($urandom_range(1, 32'((nblk - 1) > 64'd1000 ? 1000 : nblk - 1)))
                     : 64'd1;
      wp = st + m * bpb;
    end else if (kind < 85) begin
      wp = st + cap;
    end else if (kind < 95) begin
      wp = st + 64'($urandom_range(1, 7));   // torn, usually off the block grid
    end else begin
      wp = {$urandom, $urandom};
    end
    push_load(st[47:0], cfg_zsize, wp[47:0] & MASK48[47:0], cap[31:0], cond);
  endtask

  // one well-formed mount: full load, init, then a random mix of actions
  task automatic push_mount(int nops);
    int k, r;
    logic [9:0] tz;
    for (k = 0; k < int'(cfg_total); k++) begin
      if ($urandom_range(0, 40) == 0) begin
        // broken report: table is dropped and the load starts over
        push_load(48'($urandom), 32'($urandom), 48'($urandom), 32'($urandom), 4'd0);
        k = -1;
      end else begin
        push_good_zone(k < SB_ZONE_COUNT);
      end
    end
    push_op(ACT_INIT, ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1)), '0);
    for (k = 0; k < nops; k++) begin
      r = $urandom_range(0, 99);
      tz = ($urandom_range(0, 5) == 0) ? 10'($urandom)
                                       : 10'($urandom_range(0, int'(cfg_total) - 1));
      if (r < 50) push_op(ACT_ALLOC, '0, '0);
      else if (r < 70) push_op(ACT_RECLAIM, '0, tz);
      else if (r < 85) push_op(ACT_COUNT, '0, '0);
      else if (r < 89) push_good_zone(1'b0);
      else if (r < 94) push_op(ACT_INIT, 2'($urandom_range(0, 3)), '0);
      else push_op(3'($urandom_range(int'(ACT_RSVD5), int'(ACT_RSVD7))), '0, '0);
    end
  endtask

  initial begin
    int ph, tot;
    logic [31:0] bs, zs, zc;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: every action on nothing, bad geometry, reserved codes
    push_op(ACT_ALLOC, '0, '0);
    push_op(ACT_COUNT, '0, '0);
    push_op(ACT_INIT, '0, '0);
    push_op(ACT_RECLAIM, '0, 10'd5);
    push_op(ACT_RSVD5, '0, '0);
    push_op(ACT_RSVD6, '0, '0);
    push_op(ACT_RSVD7, '0, '0);
    push_load(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'h0, 32'd524288, 4'hF);
    push_load('0, 32'd524288, '0, 32'd524287, COND_EMPTY);
    wait_idle(20);

    // four zones: torn superblock, every data zone full, top-of-space start
    set_geometry(32'd8, 32'd4096, 32'd4096, 32'd4);
    push_load(48'd0, 32'd4096, 48'd3, 32'd4096, 4'd4);
    push_load(48'd4096, 32'd4096, 48'd4112, 32'd4096, 4'd4);
    push_load(48'd8192, 32'd4096, 48'd12288, 32'd4096, 4'd14);
    push_load(48'hFFFF_FFFF_F000, 32'd4096, 48'h0, 32'd4096, 4'd14);
    push_load(48'd0, 32'd4096, 48'd0, 32'd4096, COND_EMPTY);   // one too many
    push_op(ACT_INIT, 2'd2, '0);
    push_op(ACT_INIT, 2'd0, '0);
    push_op(ACT_ALLOC, '0, '0);
    push_op(ACT_RECLAIM, '0, 10'd0);
    push_op(ACT_RECLAIM, '0, 10'd4);
    push_op(ACT_RECLAIM, '0, 10'd3);
    push_op(ACT_RECLAIM, '0, 10'd3);
    push_op(ACT_COUNT, '0, '0);
    push_op(ACT_ALLOC, '0, '0);
    push_op(ACT_RECLAIM, '0, 10'd3);
    push_op(ACT_ALLOC, '0, '0);
    push_load('0, 32'd1, '0, 32'd4096, COND_EMPTY);  // drops table, head now outside
    push_op(ACT_ALLOC, '0, '0);
    wait_idle(20);

    // random mounts over a spread of geometries
    ph = 0;
    while (n_queued < 540) begin
      tx_idle = (ph % 4 != 0) && (ph != 2);
      rx_idle = (ph % 4 != 0);
      case (ph % 6)
        0: bs = 32'd1;
        1: bs = 32'd256;
        2: bs = 32'd0;
        default: bs = $urandom_range(1, 256);
      endcase
      case (ph % 5)
        0: begin zs = 32'hFFFF_FFFF; zc = 32'hFFFF_FFFF; end
        1: begin zs = 32'd1; zc = 32'd1; end
        default: begin
          zs = $urandom;
          zc = ((bs == 0) ? 32'd1 : bs) * $urandom_range(1, 4);
        end
      endcase
      tot = (ph == 3) ? 48 : ((ph == 1) ? 3 : $urandom_range(3, 12));
      set_geometry(bs, zs, zc, 32'(tot));
      if (ph == 2) hold_arm = 1'b1;
      push_mount($urandom_range(30, 50));
      wait_idle(20);
      ph++;
    end

    wait_idle(600);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: zoned_log_block_allocator.f
sv/zlba_pkg.sv
sv/zlba_mod.sv
sv/zlba_dp.sv
sv/zlba_ctrl.sv
sv/zoned_log_block_allocator.sv
verif/tb.sv
